### src/maiu_pkg.sv
// Shared types, codes and helpers for the multiply-accumulate instruction unit.
// Depends on nothing; the front, the back and the top level import it.
package maiu_pkg;

  localparam int NUM_REGS = 16;
  localparam int REG_AW = 4;
  localparam int DATA_W = 32;

  // Command queue between the front and the back, and the result queue.
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = 2;
  localparam int Q_CNT_W = 3;
  localparam int OQ_DEPTH = 2;
  localparam int OQ_PTR_W = 1;
  localparam int OQ_CNT_W = 2;

  localparam logic [1:0] OP_EXECUTE = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_READ = 2'd2;

  localparam logic [4:0] STATUS_INDEX = 5'd16;

  localparam logic [31:0] CPSR_N = 32'h8000_0000;
  localparam logic [31:0] CPSR_Z = 32'h4000_0000;
  localparam logic [31:0] CPSR_C = 32'h2000_0000;
  localparam logic [31:0] CPSR_V = 32'h1000_0000;

  typedef enum logic [3:0] {
    COND_EQ, COND_NE, COND_CS, COND_CC, COND_MI, COND_PL, COND_VS, COND_VC,
    COND_HI, COND_LS, COND_GE, COND_LT, COND_GT, COND_LE, COND_AL, COND_NV
  } cond_t;

  typedef enum logic [2:0] {
    KIND_NOP,
    KIND_MUL,
    KIND_WRITE_REG,
    KIND_WRITE_STATUS,
    KIND_READ_REG,
    KIND_READ_STATUS
  } kind_t;

  // One classified command. For register writes and reads the register
  // number travels in rd and rm.
  typedef struct packed {
    kind_t             kind;
    cond_t             cond;
    logic              accumulate;
    logic              set_flags;
    logic [REG_AW-1:0] rd;
    logic [REG_AW-1:0] rn;
    logic [REG_AW-1:0] rs;
    logic [REG_AW-1:0] rm;
    logic [DATA_W-1:0] wval;
  } item_t;

  typedef struct packed {
    logic              executed;
    logic [REG_AW-1:0] dest;
    logic [DATA_W-1:0] result;
    logic [3:0]        flags;
    logic [DATA_W-1:0] readv;
  } result_t;

  // Condition test against the flags, N in bit 3 down to V in bit 0.
  function automatic logic cond_passes(cond_t cond, logic [3:0] nzcv);
    logic n, z, c, v, ok;
    n = nzcv[3];
    z = nzcv[2];
    c = nzcv[1];
    v = nzcv[0];
    unique case (cond)
      COND_EQ: ok = z;
      COND_NE: ok = !z;
      COND_CS: ok = c;
      COND_CC: ok = !c;
      COND_MI: ok = n;
      COND_PL: ok = !n;
      COND_VS: ok = v;
      COND_VC: ok = !v;
      COND_HI: ok = c && !z;
      COND_LS: ok = !c || z;
      COND_GE: ok = (n == v);
      COND_LT: ok = (n != v);
      COND_GT: ok = !z && (n == v);
      COND_LE: ok = z || (n != v);
      COND_AL: ok = 1'b1;
      COND_NV: ok = 1'b0;
    endcase
    return ok;
  endfunction

endpackage

### src/maiu_ram.sv
// Generic single-write, single-read RAM with a registered, enabled read port.
// Depends on nothing.
module maiu_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Read-first: a read and a write to the same address return the old word.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### src/maiu_front.sv
// Front of the unit: accepts input beats, classifies them and queues them.
// Depends on maiu_pkg.
module maiu_front
  import maiu_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  in_operation,
  input  logic [31:0] in_instruction,
  input  logic [4:0]  in_reg_index,
  input  logic [31:0] in_write_value,
  output logic        q_valid,
  output item_t       q_item,
  input  logic        q_pop
);

  item_t              dec;
  item_t              q_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wp_r, rp_r;
  logic [Q_CNT_W-1:0] cnt_r, cnt_nxt;
  logic               do_push;

  always_comb begin
    dec.kind       = KIND_NOP;
    dec.cond       = cond_t'(in_instruction[31:28]);
    dec.accumulate = in_instruction[21];
    dec.set_flags  = in_instruction[20];
    dec.rd         = in_instruction[19:16];
    dec.rn         = in_instruction[15:12];
    dec.rs         = in_instruction[11:8];
    dec.rm         = in_instruction[3:0];
    dec.wval       = in_write_value;
    unique case (in_operation)
      OP_EXECUTE: begin
        dec.kind = KIND_MUL;
      end
      OP_WRITE: begin
        dec.rd = in_reg_index[REG_AW-1:0];
        if (in_reg_index < STATUS_INDEX) begin
          dec.kind = KIND_WRITE_REG;
        end else if (in_reg_index == STATUS_INDEX) begin
          dec.kind = KIND_WRITE_STATUS;
        end
      end
      OP_READ: begin
        dec.rm = in_reg_index[REG_AW-1:0];
        if (in_reg_index < STATUS_INDEX) begin
          dec.kind = KIND_READ_REG;
        end else if (in_reg_index == STATUS_INDEX) begin
          dec.kind = KIND_READ_STATUS;
        end
      end
      default: begin
        dec.kind = KIND_NOP;
      end
    endcase
  end

  assign full    = (cnt_r == Q_CNT_W'(Q_DEPTH));
  assign do_push = push && !full;
  assign q_valid = (cnt_r != '0);
  assign q_item  = q_r[rp_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_push && !q_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!do_push && q_pop) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (do_push) begin
        wp_r <= wp_r + 1'b1;
      end
      if (q_pop) begin
        rp_r <= rp_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      q_r[wp_r] <= dec;
    end
  end

endmodule

### src/maiu_back.sv
// Back of the unit: operand read, multiply, accumulate and writeback, plus the
// result queue. Depends on maiu_pkg and maiu_ram.
module maiu_back
  import maiu_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    q_valid,
  input  item_t   q_item,
  output logic    q_pop,
  input  logic    pop,
  output logic    empty,
  output result_t res
);

  // Register file: three read-port copies that are always written together.
  logic [DATA_W-1:0] ram_m, ram_s, ram_n;
  logic              wen;
  logic [REG_AW-1:0] waddr;
  logic [DATA_W-1:0] wdata;
  logic [NUM_REGS-1:0] valid_r;

  // Operand stage.
  logic              e1_valid_r;
  item_t             e1_item_r;
  logic              e1_vm_r, e1_vs_r, e1_vn_r;
  logic [DATA_W-1:0] opm, ops, opn, prod;
  logic              hazard, e1_adv, e1_ready;

  // Execute stage.
  logic              e2_valid_r;
  item_t             e2_item_r;
  logic [DATA_W-1:0] e2_prod_r, e2_acc_r, e2_rdv_r;
  logic              e2_fire, e2_writes, cond_ok, exec;
  logic [DATA_W-1:0] sum;
  logic [DATA_W-1:0] status_r, status_nxt;
  result_t           e2_res;

  // The last two register writes, for words the RAM read missed.
  logic              wb0_valid_r, wb1_valid_r;
  logic [REG_AW-1:0] wb0_addr_r, wb1_addr_r;
  logic [DATA_W-1:0] wb0_data_r, wb1_data_r;

  // Result queue.
  result_t             oq_r [OQ_DEPTH];
  logic [OQ_PTR_W-1:0] oq_wp_r, oq_rp_r;
  logic [OQ_CNT_W-1:0] oq_cnt_r;
  logic                oq_full, oq_pop;

  function automatic logic [DATA_W-1:0] fwd(
    logic [REG_AW-1:0] addr, logic [DATA_W-1:0] ram_word, logic written,
    logic v0, logic [REG_AW-1:0] a0, logic [DATA_W-1:0] d0,
    logic v1, logic [REG_AW-1:0] a1, logic [DATA_W-1:0] d1);
    logic [DATA_W-1:0] word;
    if (v0 && a0 == addr) begin
      word = d0;
    end else if (v1 && a1 == addr) begin
      word = d1;
    end else if (written) begin
      word = ram_word;
    end else begin
      word = '0;
    end
    return word;
  endfunction

  assign q_pop = q_valid && e1_ready;

  maiu_ram #(.WIDTH(DATA_W), .DEPTH(NUM_REGS)) u_ram_m (
    .clk(clk), .we(wen), .waddr(waddr), .wdata(wdata),
    .re(q_pop), .raddr(q_item.rm), .rdata(ram_m)
  );
  maiu_ram #(.WIDTH(DATA_W), .DEPTH(NUM_REGS)) u_ram_s (
    .clk(clk), .we(wen), .waddr(waddr), .wdata(wdata),
    .re(q_pop), .raddr(q_item.rs), .rdata(ram_s)
  );
  maiu_ram #(.WIDTH(DATA_W), .DEPTH(NUM_REGS)) u_ram_n (
    .clk(clk), .we(wen), .waddr(waddr), .wdata(wdata),
    .re(q_pop), .raddr(q_item.rn), .rdata(ram_n)
  );

  // Operand stage.
  always_comb begin
    opm = fwd(e1_item_r.rm, ram_m, e1_vm_r, wb0_valid_r, wb0_addr_r, wb0_data_r,
              wb1_valid_r, wb1_addr_r, wb1_data_r);
    ops = fwd(e1_item_r.rs, ram_s, e1_vs_r, wb0_valid_r, wb0_addr_r, wb0_data_r,
              wb1_valid_r, wb1_addr_r, wb1_data_r);
    opn = fwd(e1_item_r.rn, ram_n, e1_vn_r, wb0_valid_r, wb0_addr_r, wb0_data_r,
              wb1_valid_r, wb1_addr_r, wb1_data_r);
  end

  assign prod = opm * ops;

  // The item ahead may write a register this one reads; wait until it retires.
  assign e2_writes = e2_valid_r &&
                     (e2_item_r.kind == KIND_MUL || e2_item_r.kind == KIND_WRITE_REG);
  always_comb begin
    hazard = 1'b0;
    if (e2_writes) begin
      if (e1_item_r.kind == KIND_MUL) begin
        hazard = (e1_item_r.rm == e2_item_r.rd) || (e1_item_r.rs == e2_item_r.rd) ||
                 (e1_item_r.rn == e2_item_r.rd);
      end else if (e1_item_r.kind == KIND_READ_REG) begin
        hazard = (e1_item_r.rm == e2_item_r.rd);
      end
    end
  end

  assign e1_adv   = e1_valid_r && !hazard && (!e2_valid_r || e2_fire);
  assign e1_ready = !e1_valid_r || e1_adv;

  // Execute stage.
  assign e2_fire = e2_valid_r && !oq_full;
  assign cond_ok = cond_passes(e2_item_r.cond, status_r[31:28]);
  assign exec    = (e2_item_r.kind == KIND_MUL) && cond_ok;
  assign sum     = e2_prod_r + (e2_item_r.accumulate ? e2_acc_r : '0);

  always_comb begin
    status_nxt = status_r;
    if (exec && e2_item_r.set_flags) begin
      status_nxt = status_r & (CPSR_C | CPSR_V);
      if (sum[31]) begin
        status_nxt = status_nxt | CPSR_N;
      end else if (sum == '0) begin
        status_nxt = status_nxt | CPSR_Z;
      end
    end else if (e2_item_r.kind == KIND_WRITE_STATUS) begin
      status_nxt = e2_item_r.wval;
    end
  end

  assign wen   = e2_fire && (exec || e2_item_r.kind == KIND_WRITE_REG);
  assign waddr = e2_item_r.rd;
  assign wdata = exec ? sum : e2_item_r.wval;

  always_comb begin
    e2_res.executed = exec;
    e2_res.dest     = exec ? e2_item_r.rd : '0;
    e2_res.result   = exec ? sum : '0;
    e2_res.flags    = status_nxt[31:28];
    e2_res.readv    = '0;
    if (e2_item_r.kind == KIND_READ_REG) begin
      e2_res.readv = e2_rdv_r;
    end else if (e2_item_r.kind == KIND_READ_STATUS) begin
      e2_res.readv = status_r;
    end
  end

  // Result queue.
  assign empty   = (oq_cnt_r == '0);
  assign oq_full = (oq_cnt_r == OQ_CNT_W'(OQ_DEPTH));
  assign oq_pop  = pop && !empty;
  assign res     = oq_r[oq_rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e1_valid_r  <= 1'b0;
      e2_valid_r  <= 1'b0;
      status_r    <= '0;
      valid_r     <= '0;
      wb0_valid_r <= 1'b0;
      wb1_valid_r <= 1'b0;
      oq_wp_r     <= '0;
      oq_rp_r     <= '0;
      oq_cnt_r    <= '0;
    end else begin
      if (q_pop) begin
        e1_valid_r <= 1'b1;
      end else if (e1_adv) begin
        e1_valid_r <= 1'b0;
      end
      if (e1_adv) begin
        e2_valid_r <= 1'b1;
      end else if (e2_fire) begin
        e2_valid_r <= 1'b0;
      end
      if (e2_fire) begin
        status_r <= status_nxt;
        oq_wp_r  <= oq_wp_r + 1'b1;
      end
      if (wen) begin
        valid_r[waddr] <= 1'b1;
        wb0_valid_r    <= 1'b1;
        wb1_valid_r    <= wb0_valid_r;
      end
      if (oq_pop) begin
        oq_rp_r <= oq_rp_r + 1'b1;
      end
      if (e2_fire && !oq_pop) begin
        oq_cnt_r <= oq_cnt_r + 1'b1;
      end else if (!e2_fire && oq_pop) begin
        oq_cnt_r <= oq_cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      e1_item_r <= q_item;
      e1_vm_r   <= valid_r[q_item.rm];
      e1_vs_r   <= valid_r[q_item.rs];
      e1_vn_r   <= valid_r[q_item.rn];
    end
    if (e1_adv) begin
      e2_item_r <= e1_item_r;
      e2_prod_r <= prod;
      e2_acc_r  <= opn;
      e2_rdv_r  <= opm;
    end
    if (wen) begin
      wb0_addr_r <= waddr;
      wb0_data_r <= wdata;
      wb1_addr_r <= wb0_addr_r;
      wb1_data_r <= wb0_data_r;
    end
    if (e2_fire) begin
      oq_r[oq_wp_r] <= e2_res;
    end
  end

`ifndef NO_ASSERTIONS
  a_oq_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    e2_fire |-> oq_cnt_r != OQ_CNT_W'(OQ_DEPTH))
    else $error("result queue written while full");

  a_flags_only_nzcv: assert property (@(posedge clk) disable iff (!rst_n)
    (e2_fire && exec && e2_item_r.set_flags) |=> status_r[27:0] == '0)
    else $error("flag-setting multiply left low status bits set");

  a_held_operands: assert property (@(posedge clk) disable iff (!rst_n)
    (e1_valid_r && !e1_adv) |=> ($stable(ram_m) && $stable(ram_s) && $stable(ram_n)))
    else $error("operand words changed under a held item");
`endif

endmodule

### src/multiply_accumulate_instruction_unit.sv
// Top level of the multiply-accumulate instruction unit: front, command queue
// and execution back end. Depends on maiu_pkg, maiu_front and maiu_back.
//
//   Channel  Handshake           Beat fields
//   input    push / full         in_operation, in_instruction, in_reg_index,
//                                in_write_value
//   result   empty / pop         out_executed, out_dest_index, out_result_value,
//                                out_flags_nzcv, out_read_value
//
// One input beat is accepted per cycle while full is low, and each yields exactly one result beat.
// A result passes through the operand stage and the execute stage into the result queue.
// An item that reads a register written by the item directly ahead of it waits
// in the operand stage until that item retires; the flags need no such wait.
// Reset (rst_n low at a clock edge) empties both queues, clears the status word
// and clears the registers through per-register valid bits.
// A full result queue stalls the back end; the four-entry command queue keeps
// taking input beats until it too fills and raises full.
module multiply_accumulate_instruction_unit
  import maiu_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  in_operation,
  input  logic [31:0] in_instruction,
  input  logic [4:0]  in_reg_index,
  input  logic [31:0] in_write_value,
  output logic        empty,
  input  logic        pop,
  output logic        out_executed,
  output logic [3:0]  out_dest_index,
  output logic [31:0] out_result_value,
  output logic [3:0]  out_flags_nzcv,
  output logic [31:0] out_read_value
);

  logic    q_valid;
  logic    q_pop;
  item_t   q_item;
  result_t res;

  // The front decodes each beat into an item and holds it in the command queue.
  maiu_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .push           (push),
    .full           (full),
    .in_operation   (in_operation),
    .in_instruction (in_instruction),
    .in_reg_index   (in_reg_index),
    .in_write_value (in_write_value),
    .q_valid        (q_valid),
    .q_item         (q_item),
    .q_pop          (q_pop)
  );

  // The back end reads operands, multiplies, accumulates, writes back and
  // queues the result beat.
  maiu_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_pop   (q_pop),
    .pop     (pop),
    .empty   (empty),
    .res     (res)
  );

  assign out_executed     = res.executed;
  assign out_dest_index   = res.dest;
  assign out_result_value = res.result;
  assign out_flags_nzcv   = res.flags;
  assign out_read_value   = res.readv;

endmodule
